// ----- rtl/rcg_pkg.sv -----
// Ring cadence generator package: action codes, register indexes,
// reset values and the ring state record. No dependencies.
package rcg_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DUR_W = 16;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned CAD_W = 17;
  localparam int unsigned HALF_W = 9;
  localparam int unsigned DUR_REGS = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ON_FIRST = 3'd0;
  localparam cfg_idx_t REG_OFF_FIRST = 3'd1;
  localparam cfg_idx_t REG_ON_SECOND = 3'd2;
  localparam cfg_idx_t REG_OFF_SECOND = 3'd3;
  localparam cfg_idx_t REG_RING_PERIOD = 3'd4;

  localparam logic [DUR_W-1:0] ON_FIRST_RST = 16'd2000;
  localparam logic [DUR_W-1:0] OFF_FIRST_RST = 16'd4000;
  localparam logic [DUR_W-1:0] ON_SECOND_RST = 16'd0;
  localparam logic [DUR_W-1:0] OFF_SECOND_RST = 16'd0;
  localparam logic [PERIOD_W-1:0] RING_PERIOD_RST = 8'd50;

  localparam logic [CAD_W-1:0] CAD_MAX = '1;
  localparam logic [HALF_W-1:0] HALF_MAX = '1;

  typedef logic [DUR_W-1:0] dur_t;

  typedef struct packed {
    logic              ringing;
    logic              ring_mode;
    logic [CAD_W-1:0]  cad_elapsed;
    logic [HALF_W-1:0] half_elapsed;
    logic              toggle;
    logic              polarity;
    logic              lamp;
  } ring_state_t;

endpackage

// ----- rtl/rcg_if.sv -----
// Handshake channels of the ring cadence generator: command items,
// status items and register writes. Depends on rcg_pkg.
interface rcg_cmd_if;
  logic             valid;
  logic             ready;
  rcg_pkg::action_t action;
  logic             off_hook;
  modport source (output valid, action, off_hook, input ready);
  modport sink (input valid, action, off_hook, output ready);
endinterface

interface rcg_status_if;
  logic       valid;
  logic       ready;
  logic       ring_mode_pin;
  logic       polarity_pin;
  logic       ringing;
  logic       indicator_on;
  logic [1:0] cadence_step;
  modport source (output valid, ring_mode_pin, polarity_pin, ringing, indicator_on,
                  cadence_step, input ready);
  modport sink (input valid, ring_mode_pin, polarity_pin, ringing, indicator_on,
                cadence_step, output ready);
endinterface

interface rcg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rcg_pkg::CFG_IDX_W-1:0]       index;
  logic [rcg_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rcg_step.sv -----
// Next-state logic for one command item of the ring cadence generator.
// Depends on rcg_pkg.
module rcg_step #(
  parameter int unsigned STEPS = 4,
  parameter int unsigned STEP_W = 2
) (
  input  rcg_pkg::action_t                      action,
  input  logic                                  off_hook,
  input  rcg_pkg::ring_state_t                  st,
  input  logic [STEP_W-1:0]                     step,
  input  rcg_pkg::dur_t [rcg_pkg::DUR_REGS-1:0] dur,
  input  logic [rcg_pkg::PERIOD_W-1:0]          ring_period,
  output rcg_pkg::ring_state_t                  st_next,
  output logic [STEP_W-1:0]                     step_next
);
  import rcg_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  logic [STEP_W+1:0]   step_ext;
  dur_t                cur_dur;
  logic [CAD_W-1:0]    cad_inc;
  logic [HALF_W-1:0]   half_inc;
  logic [HALF_W-1:0]   half_lim;

  always_comb begin
    step_ext = {2'b00, step};
    cur_dur = dur[step_ext[1:0]];
    cad_inc = (st.cad_elapsed != CAD_MAX) ? st.cad_elapsed + 1'b1 : st.cad_elapsed;
    half_inc = (st.half_elapsed != HALF_MAX) ? st.half_elapsed + 1'b1 : st.half_elapsed;
    half_lim = {2'b00, ring_period[PERIOD_W-1:1]};
    st_next = st;
    step_next = step;
    unique case (action)
      ACT_TICK: begin
        if (st.ringing) begin
          if (off_hook) begin
            st_next.ringing = 1'b0;
            st_next.ring_mode = 1'b0;
            st_next.polarity = 1'b0;
            st_next.lamp = 1'b0;
          end else begin
            st_next.cad_elapsed = cad_inc;
            st_next.half_elapsed = half_inc;
            if (cad_inc > {1'b0, cur_dur}) begin
              st_next.cad_elapsed = '0;
              step_next = (step == LAST_STEP) ? '0 : step + 1'b1;
            end
            if (!step_next[0]) begin
              if (half_inc > half_lim) begin
                st_next.half_elapsed = '0;
                st_next.toggle = ~st.toggle;
                st_next.polarity = ~st.toggle;
                st_next.lamp = ~st.toggle;
              end
            end else begin
              st_next.polarity = 1'b0;
              st_next.lamp = 1'b0;
            end
          end
        end
      end
      ACT_START: begin
        if (!off_hook) begin
          step_next = '0;
          st_next.cad_elapsed = '0;
          st_next.half_elapsed = '0;
          st_next.ringing = 1'b1;
          st_next.ring_mode = 1'b1;
        end
      end
      ACT_STOP: begin
        st_next.ringing = 1'b0;
        st_next.ring_mode = 1'b0;
        st_next.polarity = 1'b0;
        st_next.lamp = 1'b0;
      end
      ACT_NONE: begin
        st_next = st;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

// ----- rtl/ring_cadence_generator.sv -----
// Ring cadence generator top level: register file, command input register and
// ring state / status register. Depends on rcg_pkg, rcg_if and rcg_step.
//
// Each command item (tick, start, stop or none) is taken into an input register and
// from there produces exactly one status item in the state register, showing the
// ring state after it. A new command is accepted every cycle as long as the status
// side keeps taking items; throughput is one item per clock while status is not
// stalled, and status valid is set by the state register behind the input register.
// Register writes are always accepted and must be made while no command is in
// flight. cadence_step shows the two low bits of the current cadence step.
module ring_cadence_generator #(
  parameter int unsigned CADENCE_STEPS = 4
) (
  input logic         clk,
  input logic         rst,
  rcg_cmd_if.sink     cmd,
  rcg_status_if.source status,
  rcg_cfg_if.sink     cfg
);
  import rcg_pkg::*;

  localparam int unsigned STEP_W = (CADENCE_STEPS > 2) ? $clog2(CADENCE_STEPS) : 1;

  dur_t [DUR_REGS-1:0]   dur;
  logic [PERIOD_W-1:0]   ring_period;

  logic                  in_valid;
  action_t               in_action;
  logic                  in_off_hook;

  logic                  out_valid;
  ring_state_t           st;
  ring_state_t           st_next;
  logic [STEP_W-1:0]     step;
  logic [STEP_W-1:0]     step_next;
  logic [STEP_W+1:0]     step_ext;
  logic                  advance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dur[0] <= ON_FIRST_RST;
      dur[1] <= OFF_FIRST_RST;
      dur[2] <= ON_SECOND_RST;
      dur[3] <= OFF_SECOND_RST;
      ring_period <= RING_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ON_FIRST:    dur[0] <= cfg.data;
        REG_OFF_FIRST:   dur[1] <= cfg.data;
        REG_ON_SECOND:   dur[2] <= cfg.data;
        REG_OFF_SECOND:  dur[3] <= cfg.data;
        REG_RING_PERIOD: ring_period <= cfg.data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance = !out_valid || status.ready;
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_action <= cmd.action;
      in_off_hook <= cmd.off_hook;
    end
  end

  rcg_step #(
    .STEPS  (CADENCE_STEPS),
    .STEP_W (STEP_W)
  ) u_step (
    .action      (in_action),
    .off_hook    (in_off_hook),
    .st          (st),
    .step        (step),
    .dur         (dur),
    .ring_period (ring_period),
    .st_next     (st_next),
    .step_next   (step_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      st <= '0;
      step <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        st <= st_next;
        step <= step_next;
      end
    end
  end

  assign step_ext = {2'b00, step};

  assign status.valid = out_valid;
  assign status.ring_mode_pin = st.ring_mode;
  assign status.polarity_pin = st.polarity;
  assign status.ringing = st.ringing;
  assign status.indicator_on = st.lamp;
  assign status.cadence_step = step_ext[1:0];

endmodule

// ----- rtl/rcg_checker.sv -----
// Port-level checks for the ring cadence generator status channel.
// Depends on ring_cadence_generator; attached with a bind.
module rcg_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic       ring_mode_pin,
  input logic       polarity_pin,
  input logic       ringing,
  input logic       indicator_on,
  input logic [1:0] cadence_step
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("status item dropped while stalled");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> $stable({ring_mode_pin, polarity_pin, ringing, indicator_on,
                                 cadence_step}))
    else $error("status item changed while stalled");

  a_ring_quiet: assert property (@(posedge clk) disable iff (rst)
    valid |-> (ringing == ring_mode_pin) && (ringing || (!polarity_pin && !indicator_on)))
    else $error("pins active while not ringing");

  a_lamp_follows: assert property (@(posedge clk) disable iff (rst)
    valid |-> (indicator_on == polarity_pin) && (!cadence_step[0] || !polarity_pin))
    else $error("lamp or polarity wrong for cadence step");

endmodule

bind ring_cadence_generator rcg_checker u_rcg_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (status.valid),
  .ready         (status.ready),
  .ring_mode_pin (status.ring_mode_pin),
  .polarity_pin  (status.polarity_pin),
  .ringing       (status.ringing),
  .indicator_on  (status.indicator_on),
  .cadence_step  (status.cadence_step)
);
